// File: hw/rtl/debug_port_bus_bridge_macros.svh
// Assertion macros shared by the debug port bus bridge modules.
`ifndef DEBUG_PORT_BUS_BRIDGE_MACROS_SVH
`define DEBUG_PORT_BUS_BRIDGE_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define DPBB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// When ante holds, cons must hold at the next clock edge.
`define DPBB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DPBB_ASSERT(lbl, clk, rst, prop)
`define DPBB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/dpbb_pkg.sv
// Shared types and constants of the debug port bus bridge.
`timescale 1ns / 1ps
package dpbb_pkg;

   localparam int DATA_W      = 64;
   localparam int INDEX_W     = 12;
   localparam int REGION_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 2'd1;

   localparam logic [REGION_W-1:0] REGION_LOCAL = 2'd3;

   localparam logic [INDEX_W-1:0] LW_SOFT_RESET = 12'd0;
   localparam logic [INDEX_W-1:0] LW_BUS0_WRITE = 12'd8;
   localparam logic [INDEX_W-1:0] LW_BUS0_READ  = 12'd9;
   localparam logic [INDEX_W-1:0] LW_BUS2_WRITE = 12'd12;
   localparam logic [INDEX_W-1:0] LW_BUS2_READ  = 12'd13;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RESP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_SOFT = 2'd1,
      SEL_DATA = 2'd2
   } rd_sel_type;

   // Decoded transaction handed from front to back.
   typedef struct packed {
      op_type                op;
      logic                  w32;
      logic                  addr_upper;
      logic                  off_upper;
      logic [REGION_W-1:0]   region;
      logic [INDEX_W-1:0]    index;
      rd_sel_type            rd_sel;
      logic [DATA_W-1:0]     data;
   } cmd_type;

endpackage

// File: hw/rtl/dpbb_front.sv
// Front end: window registers, offset decode and classification of transactions.
`timescale 1ns / 1ps
module dpbb_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dpbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dpbb_pkg::DATA_W-1:0]      csr_data,
   input  logic                             req_valid,
   input  logic [1:0]                       req_op,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_address,
   input  logic                             req_is_word32,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_write_data,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_dbg_read_data,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus0_write_count,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus0_read_count,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus2_write_count,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus2_read_count,
   input  logic                             queue_full,
   output logic                             push,
   output dpbb_pkg::cmd_type                push_cmd
);
   import dpbb_pkg::*;

   logic [DATA_W-1:0] base_ff;
   logic [DATA_W-1:0] mask_ff;
   logic [DATA_W-1:0] offset;
   op_type            op;
   cmd_type           cmd;

   assign csr_ready = 1'b1;

   // The offset mask is kept precomputed as length minus one.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         mask_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BASE_ADDRESS) begin
            base_ff <= csr_data;
         end else if (csr_index == CSR_WINDOW_LENGTH) begin
            mask_ff <= csr_data - DATA_W'(1);
         end
      end
   end

   assign op     = op_type'(req_op);
   assign offset = (req_address - base_ff) & mask_ff;

   always_comb begin
      cmd            = '0;
      cmd.op         = op;
      cmd.w32        = req_is_word32;
      cmd.addr_upper = req_address[2];
      cmd.off_upper  = offset[2];
      cmd.region     = offset[16:15];
      cmd.index      = offset[14:3];
      cmd.rd_sel     = SEL_ZERO;
      cmd.data       = '0;
      unique case (op)
         OP_WRITE: begin
            cmd.data = req_write_data;
         end
         OP_RESP: begin
            cmd.data = req_dbg_read_data;
         end
         OP_READ: begin
            if (offset[16:15] == REGION_LOCAL) begin
               unique case (offset[14:3])
                  LW_SOFT_RESET: cmd.rd_sel = SEL_SOFT;
                  LW_BUS0_WRITE: begin
                     cmd.rd_sel = SEL_DATA;
                     cmd.data   = req_bus0_write_count;
                  end
                  LW_BUS0_READ: begin
                     cmd.rd_sel = SEL_DATA;
                     cmd.data   = req_bus0_read_count;
                  end
                  LW_BUS2_WRITE: begin
                     cmd.rd_sel = SEL_DATA;
                     cmd.data   = req_bus2_write_count;
                  end
                  LW_BUS2_READ: begin
                     cmd.rd_sel = SEL_DATA;
                     cmd.data   = req_bus2_read_count;
                  end
                  default: cmd.rd_sel = SEL_ZERO;
               endcase
            end
         end
         default: begin
            cmd.data = '0;
         end
      endcase
   end

   // Unused op code is taken and dropped.
   assign push     = req_valid && !queue_full && (op != OP_NONE);
   assign push_cmd = cmd;

endmodule

// File: hw/rtl/dpbb_queue.sv
// Short queue of decoded transactions between front and back.
`timescale 1ns / 1ps
`include "debug_port_bus_bridge_macros.svh"
module dpbb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dpbb_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output dpbb_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import dpbb_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;

   assign full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] n;
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + QUEUE_PTR_W'(1);
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QUEUE_PTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QUEUE_PTR_W+1)'(1);
         end
      end
   end

   `DPBB_ASSERT(a_no_push_full, clock, reset, !(push && full))
   `DPBB_ASSERT(a_no_pop_empty, clock, reset, !(pop && empty))
   `DPBB_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// File: hw/rtl/dpbb_back.sv
// Back end: pairing and local register state, and the registered result stage.
`timescale 1ns / 1ps
`include "debug_port_bus_bridge_macros.svh"
module dpbb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  dpbb_pkg::cmd_type             pop_cmd,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_result_kind,
   output logic                          rsp_resp_error,
   output logic [dpbb_pkg::DATA_W-1:0]   rsp_read_data,
   output logic                          rsp_dbg_write,
   output logic [dpbb_pkg::INDEX_W-1:0]  rsp_dbg_index,
   output logic [dpbb_pkg::REGION_W-1:0] rsp_dbg_region,
   output logic [dpbb_pkg::DATA_W-1:0]   rsp_dbg_wdata,
   output logic                          rsp_cpu_reset
);
   import dpbb_pkg::*;

   logic [DATA_W-1:0]   pair_ff,  pair_in;
   logic [DATA_W-1:0]   lww_ff,   lww_in;
   logic [DATA_W-1:0]   soft_ff,  soft_in;
   logic                pend_ff,  pend_in;
   logic                valid_ff;
   logic                kind_ff,  kind_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;
   logic                dwr_ff,   dwr_in;
   logic [INDEX_W-1:0]  didx_ff,  didx_in;
   logic [REGION_W-1:0] dreg_ff,  dreg_in;
   logic [DATA_W-1:0]   dwd_ff,   dwd_in;
   logic                cpur_ff;
   logic                is_write;
   logic                commit;
   logic [DATA_W-1:0]   wr_word;
   logic [DATA_W-1:0]   local_val;

   assign pop = !queue_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      pair_in  = pair_ff;
      lww_in   = lww_ff;
      soft_in  = soft_ff;
      pend_in  = pend_ff;
      kind_in  = 1'b0;
      rdata_in = '0;
      dwr_in   = 1'b0;
      didx_in  = '0;
      dreg_in  = '0;
      dwd_in   = '0;
      commit   = 1'b0;
      is_write = (pop_cmd.op == OP_WRITE);
      wr_word  = pop_cmd.data;
      local_val = '0;
      if (pop_cmd.op == OP_RESP) begin
         rdata_in = pend_ff ? {32'b0, pop_cmd.data[63:32]} : pop_cmd.data;
      end else begin
         pend_in = pop_cmd.w32 && pop_cmd.addr_upper;
         if (is_write && pop_cmd.w32) begin
            pair_in = {pop_cmd.data[31:0], pair_ff[63:32]};
            wr_word = pair_in;
         end
         if (pop_cmd.region == REGION_LOCAL) begin
            if (is_write) begin
               if (!pop_cmd.w32) begin
                  lww_in = pop_cmd.data;
                  commit = 1'b1;
               end else if (!pop_cmd.off_upper) begin
                  lww_in = {32'b0, pop_cmd.data[31:0]};
               end else begin
                  lww_in = lww_ff | {pop_cmd.data[31:0], 32'b0};
                  commit = 1'b1;
               end
               if (commit && (pop_cmd.index == LW_SOFT_RESET)) begin
                  soft_in = lww_in;
               end
            end else begin
               unique case (pop_cmd.rd_sel)
                  SEL_SOFT: local_val = soft_ff;
                  SEL_DATA: local_val = pop_cmd.data;
                  default:  local_val = '0;
               endcase
               rdata_in = (pop_cmd.w32 && pop_cmd.off_upper) ?
                          {32'b0, local_val[63:32]} : local_val;
            end
         end else if (!(is_write && pop_cmd.w32 && !pop_cmd.addr_upper)) begin
            // Low-half 32-bit writes are answered at once; everything else issues a request.
            kind_in = 1'b1;
            dwr_in  = is_write;
            didx_in = pop_cmd.index;
            dreg_in = pop_cmd.region;
            dwd_in  = is_write ? wr_word : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff  <= '0;
         lww_ff   <= '0;
         soft_ff  <= '0;
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pair_ff <= pair_in;
            lww_ff  <= lww_in;
            soft_ff <= soft_in;
            pend_ff <= pend_in;
         end
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         rdata_ff <= rdata_in;
         dwr_ff   <= dwr_in;
         didx_ff  <= didx_in;
         dreg_ff  <= dreg_in;
         dwd_ff   <= dwd_in;
         cpur_ff  <= soft_in[0];
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_resp_error  = 1'b0;
   assign rsp_read_data   = rdata_ff;
   assign rsp_dbg_write   = dwr_ff;
   assign rsp_dbg_index   = didx_ff;
   assign rsp_dbg_region  = dreg_ff;
   assign rsp_dbg_wdata   = dwd_ff;
   assign rsp_cpu_reset   = cpur_ff;

   `DPBB_ASSERT(a_req_not_local, clock, reset, !(valid_ff && kind_ff && dreg_ff == REGION_LOCAL))
   `DPBB_ASSERT(a_bus_rsp_clean, clock, reset, !(valid_ff && !kind_ff && (dwr_ff || dwd_ff != '0)))
   `DPBB_ASSERT_NEXT(a_cpu_reset_tracks, clock, reset, pop, rsp_cpu_reset == soft_ff[0])

endmodule

// File: hw/rtl/debug_port_bus_bridge.sv
// Top level of the debug port bus bridge.
// The bridge takes one transaction per cycle on the req_ channel while req_stall is low
// (bus read, bus write or debug port response) and returns one result per transaction on
// the rsp_ channel, passing through the two-entry decode queue and then the result
// register. The queue decouples the offset decode from the back end, so req_stall rises
// only when both queue entries are held by a stalled result side. Unused op code 3 is
// accepted and dropped without a result. Window base and length are written on the csr_
// channel (index 0 base, 1 length); the user must do so only while the bridge is idle,
// which the bridge itself does not enforce. csr_ready is always high.
`timescale 1ns / 1ps
module debug_port_bus_bridge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dpbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dpbb_pkg::DATA_W-1:0]      csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_address,
   input  logic                             req_is_word32,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_write_data,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_dbg_read_data,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus0_write_count,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus0_read_count,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus2_write_count,
   input  logic [dpbb_pkg::DATA_W-1:0]      req_bus2_read_count,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_result_kind,
   output logic                             rsp_resp_error,
   output logic [dpbb_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                             rsp_dbg_write,
   output logic [dpbb_pkg::INDEX_W-1:0]     rsp_dbg_index,
   output logic [dpbb_pkg::REGION_W-1:0]    rsp_dbg_region,
   output logic [dpbb_pkg::DATA_W-1:0]      rsp_dbg_wdata,
   output logic                             rsp_cpu_reset
);
   import dpbb_pkg::*;

   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type pop_cmd;

   assign req_stall = queue_full;

   dpbb_front u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_op               (req_op),
      .req_address          (req_address),
      .req_is_word32        (req_is_word32),
      .req_write_data       (req_write_data),
      .req_dbg_read_data    (req_dbg_read_data),
      .req_bus0_write_count (req_bus0_write_count),
      .req_bus0_read_count  (req_bus0_read_count),
      .req_bus2_write_count (req_bus2_write_count),
      .req_bus2_read_count  (req_bus2_read_count),
      .queue_full           (queue_full),
      .push                 (push),
      .push_cmd             (push_cmd)
   );

   dpbb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   dpbb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .pop_cmd         (pop_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_resp_error  (rsp_resp_error),
      .rsp_read_data   (rsp_read_data),
      .rsp_dbg_write   (rsp_dbg_write),
      .rsp_dbg_index   (rsp_dbg_index),
      .rsp_dbg_region  (rsp_dbg_region),
      .rsp_dbg_wdata   (rsp_dbg_wdata),
      .rsp_cpu_reset   (rsp_cpu_reset)
   );

endmodule
